[rtl/core/ssdr_pkg.sv]
package ssdr_pkg;

  localparam int SSDR_DELAY_W = 20;
  localparam int EXP_TABLE_DEPTH_DEF = 256;
  localparam int DELAY_BITS_DEF = 20;

  localparam logic [14:0] EXP_NEG_ONE_Q16 = 15'd24109;

  typedef enum logic [2:0] {
    CFG_RAMP_MODE      = 3'd0,
    CFG_DELAY_FLOOR    = 3'd1,
    CFG_DELAY_CEILING  = 3'd2,
    CFG_DELAY_START    = 3'd3,
    CFG_HALF_STEPS     = 3'd4,
    CFG_PLATEAU_RATE   = 3'd5,
    CFG_LINEAR_DIVISOR = 3'd6
  } cfg_idx_t;

  localparam logic        RST_RAMP_MODE      = 1'b1;
  localparam logic [19:0] RST_DELAY_FLOOR    = 20'd100;
  localparam logic [19:0] RST_DELAY_CEILING  = 20'd10000;
  localparam logic [19:0] RST_DELAY_START    = 20'd10000;
  localparam logic [23:0] RST_HALF_STEPS     = 24'd1000;
  localparam logic [31:0] RST_PLATEAU_RATE   = 32'd214748;
  localparam logic [31:0] RST_LINEAR_DIVISOR = 32'd1000;

  localparam logic        FUNC_START = 1'b0;

  // Evaluates exp(-x / 2^32) in Q1.16 by a series through the x^24 term in Q32 arithmetic.
  function automatic logic [16:0] exp_series(input logic [63:0] x);
    logic [63:0]         term;
    logic [127:0]        prod;
    logic signed [67:0]  sum;
    logic [67:0]         rounded;
    term = 64'd1 << 32;
    sum  = 68'sd1 <<< 32;
    for (int n = 1; n <= 24; n++) begin
      prod = 128'(term) * 128'(x);
      term = prod[95:32];
      term = term / 64'(n);
      if ((n & 1) != 0) begin
        sum = sum - $signed({4'b0, term});
      end else begin
        sum = sum + $signed({4'b0, term});
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    rounded = $unsigned(sum) + 68'd32768;
    return rounded[32:16];
  endfunction

endpackage

[rtl/core/stepper_step_delay_ramp.sv]
// A start beat gives no result; a step beat holds the input off until its result
// is loaded. A linear step runs a bit-serial 32x24 multiply, then a restoring divide.
// A plateau step runs a bit-serial 32x32 multiply, a table look-up and repeated
// multiplies by exp(-1), then scales; the midpoint step returns the last delay
// directly and a negative mirrored time takes the ceiling to the clamp.
// Synchronous reset loads the register defaults.
module stepper_step_delay_ramp
  import ssdr_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF,
  parameter int DELAY_BITS      = DELAY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  logic [31:0]           now_us,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DELAY_BITS-1:0] delay_us
);

  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int TP_W  = 16 + IDX_W;
  localparam int SAT_BITS = (DELAY_BITS < SSDR_DELAY_W) ? DELAY_BITS : SSDR_DELAY_W;
  localparam logic [SSDR_DELAY_W-1:0] SAT_MAX =
    {SSDR_DELAY_W{1'b1}} >> (SSDR_DELAY_W - SAT_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MUL, S_DIV, S_LFIN, S_EXPO, S_TAB, S_EXP, S_SCALE, S_CLAMP, S_OUT
  } state_t;

  logic        ramp_mode;
  logic [19:0] delay_floor;
  logic [19:0] delay_ceiling;
  logic [19:0] delay_start;
  logic [23:0] half_steps;
  logic [31:0] plateau_rate;
  logic [31:0] linear_divisor;

  state_t             state;
  logic [24:0]        step_count;
  logic [31:0]        move_start_time;
  logic [31:0]        mid_elapsed;
  logic [19:0]        last_delay;
  logic [31:0]        now_q;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [31:0]        hi;
  logic [31:0]        lo;
  logic [5:0]         cnt;
  logic [31:0]        dq;
  logic [31:0]        rem;
  logic [7:0]         e_int;
  logic [IDX_W-1:0]   tab_idx;
  logic [16:0]        m;
  logic signed [33:0] val;
  logic [19:0]        res;

  logic [16:0]        exp_rom [EXP_TABLE_DEPTH];

  for (genvar gk = 0; gk < EXP_TABLE_DEPTH; gk++) begin : g_tab
    localparam logic [63:0] X = (64'(gk) << 32) / EXP_TABLE_DEPTH;
    assign exp_rom[gk] = exp_series(X);
  end

  logic [31:0]        elapsed;
  logic [32:0]        t_mirror;
  logic [31:0]        div_eff;
  logic [23:0]        hs_eff;
  logic [32:0]        mul_sum;
  logic [55:0]        den;
  logic [32:0]        r_shift;
  logic               r_ge;
  logic [32:0]        r_diff;
  logic [32:0]        q_ceil;
  logic [63:0]        prod;
  logic [23:0]        e_sat;
  logic [TP_W-1:0]    tab_prod;
  logic [31:0]        m_prod;
  logic [36:0]        scale_prod;
  logic signed [33:0] clamp_v;
  logic [19:0]        clamp_res;

  assign cfg_ready = !rst;
  assign in_ready  = (state == S_IDLE) && !rst;

  assign elapsed  = now_q - move_start_time;
  assign t_mirror = {1'b0, mid_elapsed} - {1'b0, elapsed};
  assign div_eff  = (linear_divisor == '0) ? 32'd1 : linear_divisor;
  assign hs_eff   = (half_steps == '0) ? 24'd1 : half_steps;
  assign mul_sum  = {1'b0, hi} + (mul_b[0] ? {1'b0, mul_a} : 33'd0);
  assign den      = {hi, lo[31:8]};
  assign r_shift  = {rem, dq[31]};
  assign r_ge     = (den[55:33] == '0) && (r_shift >= den[32:0]);
  assign r_diff   = r_shift - den[32:0];
  assign q_ceil   = {1'b0, dq} + ((rem != '0) ? 33'd1 : 33'd0);
  assign prod     = {hi, lo};
  assign e_sat    = (prod[63:40] != '0) ? 24'hFFFFFF : prod[39:16];
  assign tab_prod = TP_W'(e_sat[15:0]) * TP_W'(EXP_TABLE_DEPTH);
  assign m_prod   = 32'(m) * 32'(EXP_NEG_ONE_Q16) + 32'd32768;
  assign scale_prod = 37'(delay_ceiling) * 37'(m) + 37'd32768;

  always_comb begin
    clamp_v = val;
    if (clamp_v < $signed({14'b0, delay_floor})) begin
      clamp_v = $signed({14'b0, delay_floor});
    end
    if (clamp_v > $signed({14'b0, delay_ceiling})) begin
      clamp_v = $signed({14'b0, delay_ceiling});
    end
    clamp_res = clamp_v[19:0];
    if (clamp_res > SAT_MAX) begin
      clamp_res = SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_mode      <= RST_RAMP_MODE;
      delay_floor    <= RST_DELAY_FLOOR;
      delay_ceiling  <= RST_DELAY_CEILING;
      delay_start    <= RST_DELAY_START;
      half_steps     <= RST_HALF_STEPS;
      plateau_rate   <= RST_PLATEAU_RATE;
      linear_divisor <= RST_LINEAR_DIVISOR;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RAMP_MODE:      ramp_mode      <= cfg_data[0];
        CFG_DELAY_FLOOR:    delay_floor    <= cfg_data[19:0];
        CFG_DELAY_CEILING:  delay_ceiling  <= cfg_data[19:0];
        CFG_DELAY_START:    delay_start    <= cfg_data[19:0];
        CFG_HALF_STEPS:     half_steps     <= cfg_data[23:0];
        CFG_PLATEAU_RATE:   plateau_rate   <= cfg_data;
        CFG_LINEAR_DIVISOR: linear_divisor <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      step_count      <= '0;
      move_start_time <= '0;
      mid_elapsed     <= '0;
      last_delay      <= '0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (func == FUNC_START) begin
              move_start_time <= now_us;
              step_count      <= '0;
            end else begin
              step_count <= step_count + 25'd1;
              now_q      <= now_us;
              state      <= S_PREP;
            end
          end
        end
        S_PREP: begin
          hi <= '0;
          lo <= '0;
          if (!ramp_mode) begin
            mul_a <= div_eff;
            mul_b <= {8'b0, hs_eff};
            cnt   <= 6'd24;
            dq    <= elapsed;
            state <= S_MUL;
          end else if (step_count == {1'b0, half_steps}) begin
            move_start_time <= now_q;
            mid_elapsed     <= elapsed;
            res             <= last_delay;
            state           <= S_OUT;
          end else if (step_count < {1'b0, half_steps}) begin
            mul_a <= plateau_rate;
            mul_b <= elapsed;
            cnt   <= 6'd32;
            state <= S_MUL;
          end else if (t_mirror[32]) begin
            val   <= $signed({14'b0, delay_ceiling});
            state <= S_CLAMP;
          end else begin
            mul_a <= plateau_rate;
            mul_b <= t_mirror[31:0];
            cnt   <= 6'd32;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          hi    <= mul_sum[32:1];
          lo    <= {mul_sum[0], lo[31:1]};
          mul_b <= mul_b >> 1;
          if (cnt == 6'd1) begin
            if (!ramp_mode) begin
              rem   <= '0;
              cnt   <= 6'd32;
              state <= S_DIV;
            end else begin
              state <= S_EXPO;
            end
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        S_DIV: begin
          rem <= r_ge ? r_diff[31:0] : r_shift[31:0];
          dq  <= {dq[30:0], r_ge};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_LFIN;
          end
        end
        S_LFIN: begin
          val   <= $signed({14'b0, delay_start}) - $signed({1'b0, q_ceil});
          state <= S_CLAMP;
        end
        S_EXPO: begin
          e_int   <= e_sat[23:16];
          tab_idx <= tab_prod[TP_W-1:16];
          state   <= S_TAB;
        end
        S_TAB: begin
          m     <= exp_rom[tab_idx];
          state <= S_EXP;
        end
        S_EXP: begin
          if (e_int == '0 || m == '0) begin
            state <= S_SCALE;
          end else begin
            m     <= m_prod[32-1:16] == '0 ? 17'd0 : 17'(m_prod >> 16);
            e_int <= e_int - 8'd1;
          end
        end
        S_SCALE: begin
          val   <= $signed(34'(scale_prod >> 16));
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          res        <= clamp_res;
          last_delay <= clamp_res;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            delay_us  <= DELAY_BITS'(res);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_step_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && func != FUNC_START) |=> !in_ready)
    else $error("input taken while a step beat is in progress");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ({24'b0, rem} < den))
    else $error("divider remainder not below divisor");

  a_exp_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXP) |-> (m <= 17'd65536))
    else $error("exponential mantissa above one");

  a_out_saturated: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (delay_us <= DELAY_BITS'(SAT_MAX)))
    else $error("result beat above delay saturation limit");

  a_out_only_from_out_state: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT))
    else $error("result beat raised outside the output state");

endmodule

[tb/stepper_step_delay_ramp_test.sv]
`timescale 1ns / 100ps

module stepper_step_delay_ramp_test;
  import ssdr_pkg::*;

  localparam int TABLE_N = EXP_TABLE_DEPTH_DEF;
  localparam int DW = DELAY_BITS_DEF;
  localparam logic FUNC_STEP = 1'b1;
  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_PLATEAU = 1'b1;
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int ITEM_TARGET = 1750;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1_000_000;

  class step_delay_checker;
    logic        mode;
    logic [19:0] floor_us;
    logic [19:0] ceil_us;
    logic [19:0] start_us;
    logic [23:0] half;
    logic [31:0] rate;
    logic [31:0] divisor;
    logic [24:0] steps;
    logic [31:0] t0;
    logic [31:0] mid_el;
    logic [19:0] last;
    logic [31:0] exp_lut [TABLE_N];
    logic [DW-1:0] delays_due [$];
    int mismatches;

    function new();
      logic [63:0] x;
      logic [63:0] term;
      longint sum;
      for (int k = 0; k < TABLE_N; k++) begin
        x = (64'(k) << 32) / TABLE_N;
        term = 64'd1 << 32;
        sum = longint'(term);
        for (int n = 1; n <= 24; n++) begin
          term = (term * x) >> 32;
          term = term / n;
          if (n % 2 == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        exp_lut[k] = 32'((sum + 32768) >>> 16);
      end
      mode = RST_RAMP_MODE;
      floor_us = RST_DELAY_FLOOR;
      ceil_us = RST_DELAY_CEILING;
      start_us = RST_DELAY_START;
      half = RST_HALF_STEPS;
      rate = RST_PLATEAU_RATE;
      divisor = RST_LINEAR_DIVISOR;
      steps = '0;
      t0 = '0;
      mid_el = '0;
      last = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        CFG_RAMP_MODE: mode = value[0];
        CFG_DELAY_FLOOR: floor_us = value[19:0];
        CFG_DELAY_CEILING: ceil_us = value[19:0];
        CFG_DELAY_START: start_us = value[19:0];
        CFG_HALF_STEPS: half = value[23:0];
        CFG_PLATEAU_RATE: rate = value;
        CFG_LINEAR_DIVISOR: divisor = value;
        default: ;
      endcase
    endfunction

    function void note_beat(logic f, logic [31:0] now);
      logic [31:0] elapsed;
      logic [63:0] den;
      logic [63:0] q;
      logic [63:0] e;
      logic [63:0] mq;
      int idx;
      longint t;
      longint val;
      longint lo_s;
      longint hi_s;
      if (f == FUNC_START) begin
        t0 = now;
        steps = '0;
        return;
      end
      steps = steps + 25'd1;
      elapsed = now - t0;
      if (mode == MODE_LINEAR) begin
        den = 64'(divisor == 0 ? 32'd1 : divisor) * 64'(half == 0 ? 24'd1 : half);
        q = 64'(elapsed) / den;
        if (64'(elapsed) % den != 0) begin
          q = q + 1;
        end
        val = longint'({44'd0, start_us}) - longint'(q);
      end else if (steps == 25'(half)) begin
        t0 = now;
        mid_el = elapsed;
        delays_due.push_back(last);
        return;
      end else begin
        if (steps < 25'(half)) begin
          t = longint'({32'd0, elapsed});
        end else begin
          t = longint'({32'd0, mid_el}) - longint'({32'd0, elapsed});
        end
        if (t < 0) begin
          val = longint'({44'd0, ceil_us});
        end else begin
          e = (64'(rate) * 64'(t)) >> 16;
          if (e > 64'hFF_FFFF) begin
            e = 64'hFF_FFFF;
          end
          idx = (int'(e[15:0]) * TABLE_N) >> 16;
          mq = 64'(exp_lut[idx]);
          for (int i = 0; i < int'(e[23:16]) && mq != 0; i++) begin
            mq = (mq * EXP_NEG_ONE_Q16 + 64'd32768) >> 16;
          end
          val = longint'((64'(ceil_us) * mq + 64'd32768) >> 16);
        end
      end
      lo_s = longint'({44'd0, floor_us});
      hi_s = longint'({44'd0, ceil_us});
      if (val < lo_s) begin
        val = lo_s;
      end
      if (val > hi_s) begin
        val = hi_s;
      end
      last = val[19:0];
      delays_due.push_back(val[DW-1:0]);
    endfunction

    function void check_delay(logic [DW-1:0] got);
      logic [DW-1:0] want;
      if (delays_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("delay_us %0d returned with no step outstanding", got);
        end
        return;
      end
      want = delays_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("delay_us mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic [31:0] now_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DW-1:0] delay_us;

  logic hold = 1'b0;
  logic no_idle = 1'b0;
  int n_accepted = 0;
  int cycle_count = 0;
  step_delay_checker sb;

  stepper_step_delay_ramp u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .now_us(now_us),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .delay_us(delay_us)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("stepper_step_delay_ramp regression: fail");
      $finish;
    end
  end

  task automatic send_beat(logic f, logic [31:0] now);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    now_us <= now;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(f, now);
    n_accepted++;
  endtask

  task automatic set_reg(logic [2:0] idx, logic [31:0] value, int w);
    logic [31:0] junk;
    junk = $urandom;
    if (w < 32) begin
      value = ((junk >> w) << w) | value;
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.delays_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic m, logic [19:0] lo, logic [19:0] hi, logic [19:0] st,
                           logic [23:0] hs, logic [31:0] r, logic [31:0] d);
    settle();
    set_reg(CFG_RAMP_MODE, 32'(m), 1);
    set_reg(CFG_DELAY_FLOOR, 32'(lo), 20);
    set_reg(CFG_DELAY_CEILING, 32'(hi), 20);
    set_reg(CFG_DELAY_START, 32'(st), 20);
    set_reg(CFG_HALF_STEPS, 32'(hs), 24);
    set_reg(CFG_PLATEAU_RATE, r, 32);
    set_reg(CFG_LINEAR_DIVISOR, d, 32);
    set_reg(CFG_UNUSED, 32'd0, 0);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_move(bit with_start, logic [31:0] t_begin, int n, logic [31:0] dt_max);
    logic [31:0] now;
    now = t_begin;
    if (with_start) begin
      send_beat(FUNC_START, now);
    end
    repeat (n) begin
      now = now + $urandom_range(0, dt_max);
      if ($urandom_range(0, 19) == 0) begin
        send_beat(FUNC_STEP, $urandom);
      end else begin
        send_beat(FUNC_STEP, now);
      end
    end
  endtask

  // Each result taken is checked against the oldest delay still due.
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_ready) begin
        sb.check_delay(delay_us);
        stall = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (hold) begin
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : backpressure
    int marks [2];
    marks = '{500, 1300};
    foreach (marks[i]) begin
      wait (n_accepted >= marks[i]);
      @(posedge clk);
      hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold <= 1'b0;
    end
  end

  initial begin : stimulus
    int hs;
    int rs;
    int n;
    int target;
    logic m;
    logic [19:0] lo;
    logic [19:0] hi;
    logic [19:0] st;
    logic [31:0] r;
    logic [31:0] d;
    logic [31:0] dtm;
    longint den;
    longint span;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_beat(FUNC_STEP, 32'd0);
    send_beat(FUNC_START, 32'hFFFF_FFF0);
    send_beat(FUNC_STEP, 32'h0000_0010);
    send_beat(FUNC_STEP, 32'h7FFF_FFFF);

    configure(MODE_PLATEAU, 20'd0, 20'hFFFFF, 20'hFFFFF, 24'd2, 32'hFFFF_FFFF, 32'd1);
    send_beat(FUNC_START, 32'd0);
    send_beat(FUNC_STEP, 32'd1);
    send_beat(FUNC_STEP, 32'd1000);
    send_beat(FUNC_STEP, 32'd1400);
    send_beat(FUNC_STEP, 32'd3000);

    configure(MODE_PLATEAU, 20'hFFFFF, 20'd0, 20'd0, 24'd5, RST_PLATEAU_RATE, 32'd1);
    send_beat(FUNC_START, 32'd100);
    send_beat(FUNC_STEP, 32'd200);

    configure(MODE_PLATEAU, 20'd0, 20'd50000, 20'd0, 24'd0, 32'd1 << 20, 32'd1);
    send_beat(FUNC_START, 32'd5000);
    send_beat(FUNC_STEP, 32'd5000);
    send_beat(FUNC_STEP, 32'd6000);

    configure(MODE_LINEAR, 20'd0, 20'hFFFFF, 20'hFFFFF, 24'd0, 32'd0, 32'd0);
    send_beat(FUNC_START, 32'h100);
    send_beat(FUNC_STEP, 32'h100);
    send_beat(FUNC_STEP, 32'h105);
    send_beat(FUNC_STEP, 32'h0FF);

    configure(MODE_LINEAR, 20'd10, 20'd1000, 20'd0, 24'hFFFFFF, 32'd0, 32'hFFFF_FFFF);
    send_beat(FUNC_START, 32'd7);
    send_beat(FUNC_STEP, 32'd7);
    send_beat(FUNC_STEP, 32'd8);

    configure(MODE_LINEAR, 20'd500, 20'd400, 20'd450, 24'd1, 32'd0, 32'd1);
    send_beat(FUNC_STEP, 32'd9);

    while (n_accepted < ITEM_TARGET) begin
      no_idle <= ($urandom_range(0, 3) == 0);
      m = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: hi = 20'd0;
        1: hi = 20'hFFFFF;
        default: hi = 20'($urandom_range(1, 20'hFFFFF));
      endcase
      case ($urandom_range(0, 9))
        0: lo = 20'd0;
        1: lo = 20'($urandom_range(0, 20'hFFFFF));
        default: lo = 20'($urandom_range(0, hi / 4));
      endcase
      st = 20'($urandom_range(0, 20'hFFFFF));
      if (m == MODE_PLATEAU) begin
        hs = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
        rs = $urandom_range(10, 31);
        r = ($urandom | 32'h8000_0000) >> (32 - rs);
        dtm = (32'd1 << (34 - rs)) / (hs + 1);
        if ($urandom_range(0, 9) == 0) begin
          r = $urandom;
          dtm = $urandom;
        end
        d = $urandom;
      end else begin
        hs = $urandom_range(0, 64);
        d = $urandom_range(0, 1 << $urandom_range(0, 12));
        den = longint'(d == 0 ? 32'd1 : d) * longint'(hs == 0 ? 1 : hs);
        span = den * longint'(st / 16 + 1);
        dtm = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
        r = $urandom;
      end
      configure(m, lo, hi, st, 24'(hs), r, d);
      target = n_accepted + $urandom_range(40, 120);
      while (n_accepted < target) begin
        n = (m == MODE_PLATEAU) ? $urandom_range(1, 2 * hs + 4) : $urandom_range(1, 40);
        run_move($urandom_range(0, 9) != 0, $urandom, n, dtm);
      end
    end

    settle();
    if (sb.mismatches == 0 && sb.delays_due.size() == 0) begin
      $display("stepper_step_delay_ramp regression: pass");
    end else begin
      $display("stepper_step_delay_ramp regression: fail");
    end
    $finish;
  end

endmodule
